/* rtl/sha_pkg.sv */
// SHA-256 engine package: types, round constants and round functions.
// Used by every module of the engine; depends on nothing.
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       load_byte;  // write one byte into the block store
    logic [7:0] byte_val;
    logic       count_byte; // add eight to the bit count
    logic       start;      // copy chain into working variables
    logic       round;      // run one round
    logic       finish;     // add working variables into chain
    logic       restart;    // return chain and count to initial values
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
    logic [5:0] round_idx;
    logic [63:0] bit_count;
  } sha_stat_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic word_t ror(word_t x, int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha_if.sv */
// Valid/ready stream interfaces for the SHA-256 engine.
// Standalone; no package needed.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

/* rtl/sha_datapath.sv */
// SHA-256 datapath: block store, rolling message schedule, round unit, chain and count.
// Depends on sha_pkg.
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  output sha_pkg::sha_stat_t stat_o,
  input  logic [2:0]        rd_idx_i,
  output logic [31:0]       rd_word_o
);
  import sha_pkg::*;

  word_t w_q [16];
  word_t v_q [8];
  word_t h_q [8];
  logic [63:0] cnt_q;
  logic [5:0]  pos_q, rnd_q;

  word_t s0, s1, wnew, t1, t2, a, e;
  always_comb begin
    s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    a = v_q[0];
    e = v_q[4];
    t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
         + RoundK[rnd_q] + w_q[0];
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // The block store shifts down one word per round so that w_q[0] is the round's word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      unique case (pos_q[1:0])
        2'd0: w_q[pos_q[5:2]] <= {cmd_i.byte_val, 24'd0};
        2'd1: w_q[pos_q[5:2]][23:16] <= cmd_i.byte_val;
        2'd2: w_q[pos_q[5:2]][15:8] <= cmd_i.byte_val;
        default: w_q[pos_q[5:2]][7:0] <= cmd_i.byte_val;
      endcase
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (cmd_i.start) v_q <= h_q;
    else if (cmd_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= InitHash;
      cnt_q <= '0;
      pos_q <= '0;
      rnd_q <= '0;
    end else begin
      if (cmd_i.load_byte) pos_q <= pos_q + 6'd1;
      if (cmd_i.count_byte) cnt_q <= cnt_q + 64'd8;
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.finish) for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      if (cmd_i.restart) begin
        h_q <= InitHash;
        cnt_q <= '0;
        pos_q <= '0;
      end
    end
  end

  assign stat_o = '{byte_pos: pos_q, round_idx: rnd_q, bit_count: cnt_q};
  assign rd_word_o = h_q[rd_idx_i];
endmodule

/* rtl/sha_ctrl.sv */
// SHA-256 controller: accepts bytes, sequences padding, rounds and digest output.
// Depends on sha_pkg and sha_if.
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha_in_if.sink             in_i,
  sha_out_if.source          out_o,
  output sha_pkg::sha_cmd_t  cmd_o,
  input  sha_pkg::sha_stat_t stat_i,
  output logic [2:0]         rd_idx_o,
  input  logic [31:0]        rd_word_i
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_FINISH, S_PAD, S_OUT
  } state_e;

  state_e     state_q;
  logic       last_q;    // message ends once the current block is done
  logic       padding_q; // inside padding (0x80 already written)
  logic       late_q;    // 0x80 landed in the length field, so this block ends in zeros
  logic       lenw_q;    // the block being compressed carries the length field
  logic [63:0] len_q;
  logic [2:0] idx_q;
  logic       ovalid_q;
  logic [31:0] oword_q;

  logic acc;
  assign in_i.ready = (state_q == S_IDLE) && !ovalid_q;
  assign acc = in_i.valid && in_i.ready;
  assign rd_idx_o = idx_q;

  logic [7:0] pad_byte;
  always_comb begin
    if (!padding_q) pad_byte = PadMark;
    else if (stat_i.byte_pos >= LenPos && !late_q)
      pad_byte = len_q[8'(7 - stat_i.byte_pos[2:0]) * 8 +: 8];
    else pad_byte = 8'd0;
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: if (acc && in_i.byte_valid) begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_val = in_i.data_byte;
        cmd_o.count_byte = 1'b1;
        cmd_o.start = (stat_i.byte_pos == 6'd63);
      end
      S_PAD: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_val = pad_byte;
        cmd_o.start = (stat_i.byte_pos == 6'd63);
      end
      S_ROUND: cmd_o.round = 1'b1;
      S_FINISH: cmd_o.finish = 1'b1;
      S_OUT: cmd_o.restart = ovalid_q && out_o.ready && (idx_q == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q <= 1'b0;
      padding_q <= 1'b0;
      late_q <= 1'b0;
      lenw_q <= 1'b0;
      len_q <= '0;
      idx_q <= '0;
      ovalid_q <= 1'b0;
      oword_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (acc) begin
          last_q <= in_i.last_byte;
          len_q <= stat_i.bit_count + (in_i.byte_valid ? 64'd8 : 64'd0);
          if (in_i.byte_valid && stat_i.byte_pos == 6'd63) state_q <= S_ROUND;
          else if (in_i.last_byte) state_q <= S_PAD;
        end
        S_PAD: begin
          padding_q <= 1'b1;
          if (!padding_q && stat_i.byte_pos >= LenPos && stat_i.byte_pos != 6'd63)
            late_q <= 1'b1;
          if (padding_q && stat_i.byte_pos == 6'd63) begin
            late_q <= 1'b0;
            lenw_q <= !late_q;
          end
          if (stat_i.byte_pos == 6'd63) state_q <= S_ROUND;
        end
        S_ROUND: if (stat_i.round_idx == 6'd63) state_q <= S_FINISH;
        S_FINISH: begin
          if (!last_q) state_q <= S_IDLE;
          else if (lenw_q) begin
            state_q <= S_OUT;
            idx_q <= '0;
          end else state_q <= S_PAD;
        end
        S_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            oword_q <= rd_word_i;
          end else if (out_o.ready) begin
            ovalid_q <= 1'b0;
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= S_IDLE;
              last_q <= 1'b0;
              padding_q <= 1'b0;
              lenw_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.digest_word = oword_q;
  assign out_o.word_index = idx_q;
  assign out_o.final_word = (idx_q == 3'd7);
endmodule

/* rtl/sha256_hash_engine_core.sv */
// SHA-256 hash engine top level: ties the controller to the datapath.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_datapath.
//
// Usage: bytes enter on in_i (valid/ready); a transaction carries data_byte, byte_valid
// and last_byte. A transaction with byte_valid low and last_byte low does nothing.
// Ordinary bytes are accepted one per cycle. The byte that fills a 64-byte block is
// followed by compression (64 rounds, one per cycle, plus the chain update), during
// which in_i.ready is low. After last_byte the controller writes the padding one byte
// per cycle and compresses one or two more blocks, then presents eight digest words on
// out_o, word 0 first, final_word set on word 7; each word is registered before it is
// presented, and the next word is fetched only once the receiver has taken it. A stalled
// receiver simply holds the word; no input is taken until all eight words have gone.
// Reset returns the chain value to the initial hash, clears the bit count and byte
// position, and leaves the block store unset.
module sha256_hash_engine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [2:0] rd_idx;
  logic [31:0] rd_word;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_i, .out_o,
    .cmd_o(cmd), .stat_i(stat), .rd_idx_o(rd_idx), .rd_word_i(rd_word)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .rd_idx_i(rd_idx), .rd_word_o(rd_word)
  );
endmodule
